FILE: rtl/zncc_template_match_defines.svh
// Assertion macros used by the top RTL file of the template matcher.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ZNCC_TEMPLATE_MATCH_DEFINES_SVH
`define ZNCC_TEMPLATE_MATCH_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ZNCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ZNCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/zncc_pkg.sv
// ----------------------------------------------------------------------------
// zncc_pkg
// Shared types and constants of the template matcher.
// ----------------------------------------------------------------------------
package zncc_pkg;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_WAIT,
    S_ACC,
    S_DRAIN,
    S_VP,
    S_QBIT,
    S_NEXT,
    S_FINISH
  } zncc_state_t;

  typedef enum logic [3:0] {
    OP_NST2,
    OP_STST,
    OP_NSP2,
    OP_SPSP,
    OP_NSTP,
    OP_STSP,
    OP_D,
    OP_RHS,
    OP_CSQ,
    OP_LHS
  } zncc_op_t;

  localparam logic [1:0] CFG_IMAGE_W    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_H    = 2'd1;
  localparam logic [1:0] CFG_TEMPLATE_W = 2'd2;
  localparam logic [1:0] CFG_TEMPLATE_H = 2'd3;

  localparam logic [14:0] SCORE_SAT = 15'h7fff;

endpackage

FILE: rtl/zncc_template_match.sv
// Load phase: one pixel word per cycle, also while an earlier result word waits.
// Once both stores are full and the output register is free, the search runs; no input
// word is taken until its result word has been written to the output register.
// Search: per window, the template area is accumulated, then the serial multiplier forms the
// variances and numerator, and the score is found one bit at a time by serial multiplications.
// Synchronous active-low reset clears the control state and restores the default sizes.
// ----------------------------------------------------------------------------
// zncc_template_match
// Template matching by zero-mean normalised cross-correlation with an exact
// integer score and a bitwise square-root-free comparison.
// ----------------------------------------------------------------------------
`include "zncc_template_match_defines.svh"

module zncc_template_match import zncc_pkg::*; #(
  parameter int MAX_IMAGE_W     = 256,
  parameter int MAX_IMAGE_H     = 256,
  parameter int MAX_TEMPLATE_W  = 32,
  parameter int MAX_TEMPLATE_H  = 32,
  parameter int SCORE_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_match_x,
  output logic [7:0]  out_match_y,
  output logic [14:0] out_best_score,
  output logic        out_found,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int F         = SCORE_FRAC_BITS;
  localparam int IMG_DEPTH = MAX_IMAGE_W * MAX_IMAGE_H;
  localparam int NMAX      = MAX_TEMPLATE_W * MAX_TEMPLATE_H;
  localparam int IA_W      = $clog2(IMG_DEPTH);
  localparam int TA_W      = (NMAX > 1) ? $clog2(NMAX) : 1;
  localparam int IW_W      = $clog2(MAX_IMAGE_W + 1);
  localparam int IH_W      = $clog2(MAX_IMAGE_H + 1);
  localparam int TW_W      = $clog2(MAX_TEMPLATE_W + 1);
  localparam int TH_W      = $clog2(MAX_TEMPLATE_H + 1);
  localparam int IC_W      = $clog2(IMG_DEPTH + 1);
  localparam int N_W       = $clog2(NMAX + 1);
  localparam int ST_W      = N_W + 8;
  localparam int ST2_W     = N_W + 16;
  localparam int V_W       = N_W + ST2_W;
  localparam int Q_W       = F + 1;
  localparam int BIT_W     = $clog2(Q_W);
  localparam int MA_W      = 2 * V_W;
  localparam int MB_W      = (V_W > 2 * Q_W) ? V_W : 2 * Q_W;
  localparam int P_W       = MA_W + MB_W;
  localparam int CMP_W     = P_W + 2 * F;
  localparam int CW        = ((IW_W > TW_W) ? IW_W : TW_W) + 1;
  localparam int RW        = ((IH_W > TH_W) ? IH_W : TH_W) + 1;
  localparam int IW_RST    = (MAX_IMAGE_W < 256) ? MAX_IMAGE_W : 256;
  localparam int IH_RST    = (MAX_IMAGE_H < 256) ? MAX_IMAGE_H : 256;
  localparam int TW_RST    = (MAX_TEMPLATE_W < 32) ? MAX_TEMPLATE_W : 32;
  localparam int TH_RST    = (MAX_TEMPLATE_H < 32) ? MAX_TEMPLATE_H : 32;

  zncc_state_t      state_r, state_nxt;
  zncc_op_t         op_r, op_nxt;
  logic [IW_W-1:0]  img_w_r, img_w_nxt;
  logic [IH_W-1:0]  img_h_r, img_h_nxt;
  logic [TW_W-1:0]  tpl_w_r, tpl_w_nxt;
  logic [TH_W-1:0]  tpl_h_r, tpl_h_nxt;
  logic [N_W-1:0]   tpl_cnt_r, tpl_cnt_nxt;
  logic [IC_W-1:0]  img_cnt_r, img_cnt_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic [ST2_W-1:0] st2_r, st2_nxt;
  logic [IW_W-1:0]  x_r, x_nxt;
  logic [IH_W-1:0]  y_r, y_nxt;
  logic [IA_W-1:0]  wb_r, wb_nxt;
  logic [IA_W-1:0]  ybase_r, ybase_nxt;
  logic [IA_W-1:0]  ra_r, ra_nxt;
  logic [TW_W-1:0]  c_r, c_nxt;
  logic [TH_W-1:0]  row_r, row_nxt;
  logic [TA_W-1:0]  k_r, k_nxt;
  logic             acc_vld_r, acc_vld_nxt;
  logic [ST_W-1:0]  sp_r, sp_nxt;
  logic [ST2_W-1:0] sp2_r, sp2_nxt;
  logic [ST2_W-1:0] stp_r, stp_nxt;
  logic [V_W-1:0]   tmp_r, tmp_nxt;
  logic [V_W-1:0]   vt_r, vt_nxt;
  logic [V_W-1:0]   vp_r, vp_nxt;
  logic [V_W-1:0]   num_r, num_nxt;
  logic [MA_W-1:0]  d_r, d_nxt;
  logic [MA_W-1:0]  rhs_r, rhs_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [Q_W-1:0]   cand_r, cand_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [Q_W-1:0]   best_q_r, best_q_nxt;
  logic [IW_W-1:0]  best_x_r, best_x_nxt;
  logic [IH_W-1:0]  best_y_r, best_y_nxt;
  logic             status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_x_r, out_x_nxt;
  logic [7:0]       out_y_r, out_y_nxt;
  logic [14:0]      out_best_r, out_best_nxt;
  logic             out_found_r, out_found_nxt;
  logic             out_status_r, out_status_nxt;

  logic [TW_W+TH_W-1:0] ntpl_full;
  logic [IW_W+IH_W-1:0] nimg_full;
  logic [N_W-1:0]       n;
  logic                 tpl_full;
  logic                 img_full;
  logic                 too_big;
  logic                 in_acc;
  logic                 img_we;
  logic                 tpl_we;
  logic [IA_W-1:0]      img_raddr;
  logic [7:0]           img_rdata;
  logic [7:0]           tpl_rdata;
  logic [15:0]          pp;
  logic [15:0]          tp;
  logic                 mul_start;
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic                 mul_busy;
  logic                 mul_done;
  logic [P_W-1:0]       mul_p;
  logic [V_W-1:0]       mul_lo;
  logic [CMP_W-1:0]     rhs_sh;
  logic [Q_W-1:0]       cand;
  logic [Q_W-1:0]       limit;
  logic [IW_W+8:0]      cfg_w_ext;
  logic [IH_W+8:0]      cfg_h_ext;
  logic [TW_W+8:0]      cfg_tw_ext;
  logic [TH_W+8:0]      cfg_th_ext;
  logic [IW_W+7:0]      bx_ext;
  logic [IH_W+7:0]      by_ext;
  logic [Q_W+14:0]      bq_ext;

  assign ntpl_full = tpl_w_r * tpl_h_r;
  assign nimg_full = img_w_r * img_h_r;
  assign n         = ntpl_full[N_W-1:0];
  assign tpl_full  = tpl_cnt_r >= n;
  assign img_full  = img_cnt_r >= nimg_full;
  assign too_big   = (CW'(tpl_w_r) > CW'(img_w_r)) || (RW'(tpl_h_r) > RW'(img_h_r));
  assign in_stall  = (state_r != S_LOAD) || (tpl_full && img_full);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign img_raddr = ra_r + IA_W'(c_r);
  assign pp        = img_rdata * img_rdata;
  assign tp        = tpl_rdata * img_rdata;
  assign mul_lo    = mul_p[V_W-1:0];
  assign rhs_sh    = CMP_W'({rhs_r, (2 * F)'(0)});
  assign limit     = Q_W'(1) << F;
  assign cand      = q_r | (Q_W'(1) << bit_r);
  assign cfg_w_ext  = {{IW_W{1'b0}}, cfg_data};
  assign cfg_h_ext  = {{IH_W{1'b0}}, cfg_data};
  assign cfg_tw_ext = {{TW_W{1'b0}}, 3'b000, cfg_data[5:0]};
  assign cfg_th_ext = {{TH_W{1'b0}}, 3'b000, cfg_data[5:0]};
  assign bx_ext     = {8'b0, best_x_r};
  assign by_ext     = {8'b0, best_y_r};
  assign bq_ext     = {15'b0, best_q_r};

  zncc_store #(
    .IMG_DEPTH (IMG_DEPTH),
    .TPL_DEPTH (NMAX),
    .IA_W      (IA_W),
    .TA_W      (TA_W)
  ) u_store (
    .clk       (clk),
    .img_we    (img_we),
    .img_waddr (img_cnt_r[IA_W-1:0]),
    .tpl_we    (tpl_we),
    .tpl_waddr (tpl_cnt_r[TA_W-1:0]),
    .wdata     (in_pixel),
    .img_raddr (img_raddr),
    .tpl_raddr (k_r),
    .img_rdata (img_rdata),
    .tpl_rdata (tpl_rdata)
  );

  zncc_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    img_w_nxt      = img_w_r;
    img_h_nxt      = img_h_r;
    tpl_w_nxt      = tpl_w_r;
    tpl_h_nxt      = tpl_h_r;
    tpl_cnt_nxt    = tpl_cnt_r;
    img_cnt_nxt    = img_cnt_r;
    st_nxt         = st_r;
    st2_nxt        = st2_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    wb_nxt         = wb_r;
    ybase_nxt      = ybase_r;
    ra_nxt         = ra_r;
    c_nxt          = c_r;
    row_nxt        = row_r;
    k_nxt          = k_r;
    acc_vld_nxt    = (state_r == S_ACC);
    sp_nxt         = sp_r;
    sp2_nxt        = sp2_r;
    stp_nxt        = stp_r;
    tmp_nxt        = tmp_r;
    vt_nxt         = vt_r;
    vp_nxt         = vp_r;
    num_nxt        = num_r;
    d_nxt          = d_r;
    rhs_nxt        = rhs_r;
    q_nxt          = q_r;
    cand_nxt       = cand_r;
    bit_nxt        = bit_r;
    best_q_nxt     = best_q_r;
    best_x_nxt     = best_x_r;
    best_y_nxt     = best_y_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_best_nxt   = out_best_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    img_we         = 1'b0;
    tpl_we         = 1'b0;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;

    if (in_acc) begin
      if (!in_req_type) begin
        if (!tpl_full) begin
          tpl_we      = 1'b1;
          tpl_cnt_nxt = tpl_cnt_r + N_W'(1);
          st_nxt      = st_r + ST_W'(in_pixel);
          st2_nxt     = st2_r + ST2_W'({8'b0, in_pixel} * {8'b0, in_pixel});
        end
      end else if (!img_full) begin
        img_we      = 1'b1;
        img_cnt_nxt = img_cnt_r + IC_W'(1);
      end
    end

    if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_W: begin
          if (cfg_w_ext == '0) begin
            img_w_nxt = IW_W'(1);
          end else if (cfg_w_ext > (IW_W + 9)'(MAX_IMAGE_W)) begin
            img_w_nxt = IW_W'(MAX_IMAGE_W);
          end else begin
            img_w_nxt = cfg_w_ext[IW_W-1:0];
          end
        end
        CFG_IMAGE_H: begin
          if (cfg_h_ext == '0) begin
            img_h_nxt = IH_W'(1);
          end else if (cfg_h_ext > (IH_W + 9)'(MAX_IMAGE_H)) begin
            img_h_nxt = IH_W'(MAX_IMAGE_H);
          end else begin
            img_h_nxt = cfg_h_ext[IH_W-1:0];
          end
        end
        CFG_TEMPLATE_W: begin
          if (cfg_tw_ext == '0) begin
            tpl_w_nxt = TW_W'(1);
          end else if (cfg_tw_ext > (TW_W + 9)'(MAX_TEMPLATE_W)) begin
            tpl_w_nxt = TW_W'(MAX_TEMPLATE_W);
          end else begin
            tpl_w_nxt = cfg_tw_ext[TW_W-1:0];
          end
        end
        default: begin
          if (cfg_th_ext == '0) begin
            tpl_h_nxt = TH_W'(1);
          end else if (cfg_th_ext > (TH_W + 9)'(MAX_TEMPLATE_H)) begin
            tpl_h_nxt = TH_W'(MAX_TEMPLATE_H);
          end else begin
            tpl_h_nxt = cfg_th_ext[TH_W-1:0];
          end
        end
      endcase
      tpl_cnt_nxt = '0;
      img_cnt_nxt = '0;
      st_nxt      = '0;
      st2_nxt     = '0;
    end

    if (acc_vld_r) begin
      sp_nxt  = sp_r + ST_W'(img_rdata);
      sp2_nxt = sp2_r + ST2_W'(pp);
      stp_nxt = stp_r + ST2_W'(tp);
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (tpl_full && img_full && !out_valid_r) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        best_q_nxt = '0;
        best_x_nxt = '0;
        best_y_nxt = '0;
        status_nxt = too_big;
        x_nxt      = '0;
        y_nxt      = '0;
        wb_nxt     = '0;
        ybase_nxt  = '0;
        ra_nxt     = '0;
        c_nxt      = '0;
        row_nxt    = '0;
        k_nxt      = '0;
        sp_nxt     = '0;
        sp2_nxt    = '0;
        stp_nxt    = '0;
        if (too_big) begin
          state_nxt = S_FINISH;
        end else begin
          mul_start = 1'b1;
          mul_a     = MA_W'(n);
          mul_b     = MB_W'(st2_r);
          op_nxt    = OP_NST2;
          state_nxt = S_WAIT;
        end
      end
      S_ACC: begin
        k_nxt = k_r + TA_W'(1);
        if (c_r == tpl_w_r - TW_W'(1)) begin
          c_nxt   = '0;
          row_nxt = row_r + TH_W'(1);
          ra_nxt  = ra_r + IA_W'(img_w_r);
          if (row_r == tpl_h_r - TH_W'(1)) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          c_nxt = c_r + TW_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_VP;
      end
      S_VP: begin
        q_nxt     = '0;
        mul_start = 1'b1;
        mul_a     = MA_W'(n);
        mul_b     = MB_W'(sp2_r);
        op_nxt    = OP_NSP2;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_NST2: begin
              tmp_nxt   = mul_lo;
              mul_start = 1'b1;
              mul_a     = MA_W'(st_r);
              mul_b     = MB_W'(st_r);
              op_nxt    = OP_STST;
            end
            OP_STST: begin
              if (tmp_r > mul_lo) begin
                vt_nxt    = tmp_r - mul_lo;
                state_nxt = S_ACC;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            OP_NSP2: begin
              tmp_nxt   = mul_lo;
              mul_start = 1'b1;
              mul_a     = MA_W'(sp_r);
              mul_b     = MB_W'(sp_r);
              op_nxt    = OP_SPSP;
            end
            OP_SPSP: begin
              if (tmp_r > mul_lo) begin
                vp_nxt    = tmp_r - mul_lo;
                mul_start = 1'b1;
                mul_a     = MA_W'(n);
                mul_b     = MB_W'(stp_r);
                op_nxt    = OP_NSTP;
              end else begin
                state_nxt = S_NEXT;
              end
            end
            OP_NSTP: begin
              tmp_nxt   = mul_lo;
              mul_start = 1'b1;
              mul_a     = MA_W'(st_r);
              mul_b     = MB_W'(sp_r);
              op_nxt    = OP_STSP;
            end
            OP_STSP: begin
              if (tmp_r > mul_lo) begin
                num_nxt   = tmp_r - mul_lo;
                mul_start = 1'b1;
                mul_a     = MA_W'(vt_r);
                mul_b     = MB_W'(vp_r);
                op_nxt    = OP_D;
              end else begin
                state_nxt = S_NEXT;
              end
            end
            OP_D: begin
              d_nxt     = mul_p[MA_W-1:0];
              mul_start = 1'b1;
              mul_a     = MA_W'(num_r);
              mul_b     = MB_W'(num_r);
              op_nxt    = OP_RHS;
            end
            OP_RHS: begin
              rhs_nxt   = mul_p[MA_W-1:0];
              bit_nxt   = BIT_W'(F);
              state_nxt = S_QBIT;
            end
            OP_CSQ: begin
              mul_start = 1'b1;
              mul_a     = d_r;
              mul_b     = MB_W'(mul_p[2*Q_W-1:0]);
              op_nxt    = OP_LHS;
            end
            default: begin
              if (CMP_W'(mul_p) <= rhs_sh) begin
                q_nxt = cand_r;
              end
              if (bit_r == '0) begin
                state_nxt = S_NEXT;
              end else begin
                bit_nxt   = bit_r - BIT_W'(1);
                state_nxt = S_QBIT;
              end
            end
          endcase
        end
      end
      S_QBIT: begin
        cand_nxt = cand;
        if (cand > limit) begin
          if (bit_r == '0) begin
            state_nxt = S_NEXT;
          end else begin
            bit_nxt = bit_r - BIT_W'(1);
          end
        end else begin
          mul_start = 1'b1;
          mul_a     = MA_W'(cand);
          mul_b     = MB_W'(cand);
          op_nxt    = OP_CSQ;
          state_nxt = S_WAIT;
        end
      end
      S_NEXT: begin
        if (q_r > best_q_r) begin
          best_q_nxt = q_r;
          best_x_nxt = x_r;
          best_y_nxt = y_r;
        end
        c_nxt     = '0;
        row_nxt   = '0;
        k_nxt     = '0;
        sp_nxt    = '0;
        sp2_nxt   = '0;
        stp_nxt   = '0;
        state_nxt = S_ACC;
        if (CW'(x_r) + CW'(tpl_w_r) + CW'(1) <= CW'(img_w_r)) begin
          x_nxt  = x_r + IW_W'(1);
          wb_nxt = wb_r + IA_W'(1);
          ra_nxt = wb_r + IA_W'(1);
        end else begin
          x_nxt     = '0;
          y_nxt     = y_r + IH_W'(1);
          ybase_nxt = ybase_r + IA_W'(img_w_r);
          wb_nxt    = ybase_r + IA_W'(img_w_r);
          ra_nxt    = ybase_r + IA_W'(img_w_r);
          if (RW'(y_r) + RW'(tpl_h_r) + RW'(1) > RW'(img_h_r)) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        out_valid_nxt  = 1'b1;
        out_x_nxt      = bx_ext[7:0];
        out_y_nxt      = by_ext[7:0];
        out_best_nxt   = (bq_ext > (Q_W + 15)'(SCORE_SAT)) ? SCORE_SAT : bq_ext[14:0];
        out_found_nxt  = (best_q_r != '0);
        out_status_nxt = status_r;
        tpl_cnt_nxt    = '0;
        img_cnt_nxt    = '0;
        st_nxt         = '0;
        st2_nxt        = '0;
        state_nxt      = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      op_r        <= OP_NST2;
      img_w_r     <= IW_W'(IW_RST);
      img_h_r     <= IH_W'(IH_RST);
      tpl_w_r     <= TW_W'(TW_RST);
      tpl_h_r     <= TH_W'(TH_RST);
      tpl_cnt_r   <= '0;
      img_cnt_r   <= '0;
      st_r        <= '0;
      st2_r       <= '0;
      acc_vld_r   <= 1'b0;
      best_q_r    <= '0;
      best_x_r    <= '0;
      best_y_r    <= '0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      img_w_r     <= img_w_nxt;
      img_h_r     <= img_h_nxt;
      tpl_w_r     <= tpl_w_nxt;
      tpl_h_r     <= tpl_h_nxt;
      tpl_cnt_r   <= tpl_cnt_nxt;
      img_cnt_r   <= img_cnt_nxt;
      st_r        <= st_nxt;
      st2_r       <= st2_nxt;
      acc_vld_r   <= acc_vld_nxt;
      best_q_r    <= best_q_nxt;
      best_x_r    <= best_x_nxt;
      best_y_r    <= best_y_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    wb_r         <= wb_nxt;
    ybase_r      <= ybase_nxt;
    ra_r         <= ra_nxt;
    c_r          <= c_nxt;
    row_r        <= row_nxt;
    k_r          <= k_nxt;
    sp_r         <= sp_nxt;
    sp2_r        <= sp2_nxt;
    stp_r        <= stp_nxt;
    tmp_r        <= tmp_nxt;
    vt_r         <= vt_nxt;
    vp_r         <= vp_nxt;
    num_r        <= num_nxt;
    d_r          <= d_nxt;
    rhs_r        <= rhs_nxt;
    q_r          <= q_nxt;
    cand_r       <= cand_nxt;
    bit_r        <= bit_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_best_r   <= out_best_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_match_x    = out_x_r;
  assign out_match_y    = out_y_r;
  assign out_best_score = out_best_r;
  assign out_found      = out_found_r;
  assign out_status     = out_status_r;

  `ZNCC_ASSERT_NEXT(a_out_held, out_valid_r && out_stall,
                    out_valid_r && $stable(out_best_r) && $stable(out_x_r),
                    "result word changed while stalled")
  `ZNCC_ASSERT_SAME(a_mul_started_idle, mul_start, !mul_busy,
                    "multiplier started while busy")
  `ZNCC_ASSERT_SAME(a_error_has_no_match, out_valid_r && out_status_r,
                    !out_found_r && out_best_r == '0,
                    "oversized template reported with a match")
  `ZNCC_ASSERT_NEXT(a_finish_gives_word, state_r == S_FINISH, out_valid_r,
                    "finished search without a result word")

endmodule

FILE: rtl/zncc_mul.sv
// ----------------------------------------------------------------------------
// zncc_mul
// Shift-and-add multiplier, one multiplier bit per cycle; it finishes as soon
// as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module zncc_mul import zncc_pkg::*; #(
  parameter int A_W = 8,
  parameter int B_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic               done,
  output logic [A_W+B_W-1:0] p
);

  localparam int P_W = A_W + B_W;

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [P_W-1:0] a_r, a_nxt;
  logic [B_W-1:0] b_r, b_nxt;
  logic [P_W-1:0] p_r, p_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = P_W'(a);
      b_nxt    = b;
      p_nxt    = '0;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) begin
          p_nxt = p_r + a_r;
        end
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = p_r;

endmodule

FILE: rtl/zncc_store.sv
// ----------------------------------------------------------------------------
// zncc_store
// Image and template pixel memories, one write and one registered read port
// each.
// ----------------------------------------------------------------------------
module zncc_store import zncc_pkg::*; #(
  parameter int IMG_DEPTH = 65536,
  parameter int TPL_DEPTH = 1024,
  parameter int IA_W      = 16,
  parameter int TA_W      = 10
) (
  input  logic            clk,
  input  logic            img_we,
  input  logic [IA_W-1:0] img_waddr,
  input  logic            tpl_we,
  input  logic [TA_W-1:0] tpl_waddr,
  input  logic [7:0]      wdata,
  input  logic [IA_W-1:0] img_raddr,
  input  logic [TA_W-1:0] tpl_raddr,
  output logic [7:0]      img_rdata,
  output logic [7:0]      tpl_rdata
);

  logic [7:0] img_mem [IMG_DEPTH];
  logic [7:0] tpl_mem [TPL_DEPTH];
  logic [7:0] img_rdata_r;
  logic [7:0] tpl_rdata_r;

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= wdata;
    end
    img_rdata_r <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (tpl_we) begin
      tpl_mem[tpl_waddr] <= wdata;
    end
    tpl_rdata_r <= tpl_mem[tpl_raddr];
  end

  assign img_rdata = img_rdata_r;
  assign tpl_rdata = tpl_rdata_r;

endmodule

FILE: verif/tb_zncc_template_match.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ZNCC template matcher testbench
// Loads template and image words under random gaps and output stalls, works
// out the best window of every frame with an exact integer model of the
// correlation score, and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb_zncc_template_match import zncc_pkg::*;;

  localparam bit TPL = 1'b0;
  localparam bit IMG = 1'b1;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [14:0] score;
    logic        found;
    logic        status;
  } match_t;

  typedef struct packed {
    bit         is_cfg;
    logic [1:0] idx;
    logic [8:0] data;
    bit         kind;
    bit [7:0]   pix;
    bit         typed;
    match_t     res;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [7:0]  in_pixel;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_match_x;
  logic [7:0]  out_match_y;
  logic [14:0] out_best_score;
  logic        out_found;
  logic        out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  zncc_template_match DUT (.*);

  // Frame state mirrored from the block
  int unsigned     img_w, img_h, tpl_w, tpl_h, tpl_cnt, img_cnt;
  longint unsigned tpl_sum, tpl_sq;
  bit [7:0]        tpl_mem [1024];
  bit [7:0]        img_mem [65536];

  match_t pending_matches[$];
  int     errors;
  int     words_sent;
  int     matches_seen;
  int     settings_used;
  bit     hold_req;

  always #10 clk = ~clk;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned mask,
                                             int unsigned maxv);
    v &= mask;
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void clear_frame();
    tpl_cnt = 0;
    img_cnt = 0;
    tpl_sum = 0;
    tpl_sq  = 0;
  endfunction

  function automatic void match_config(logic [1:0] idx, logic [8:0] d);
    case (idx)
      CFG_IMAGE_W:    img_w = clamp_size(d, 'h1ff, 256);
      CFG_IMAGE_H:    img_h = clamp_size(d, 'h1ff, 256);
      CFG_TEMPLATE_W: tpl_w = clamp_size(d, 'h3f, 32);
      CFG_TEMPLATE_H: tpl_h = clamp_size(d, 'h3f, 32);
      default: ;
    endcase
    clear_frame();
  endfunction

  function automatic int unsigned zncc_q(longint unsigned num, longint unsigned vt,
                                         longint unsigned vp);
    logic [255:0] rhs, d, lhs;
    int unsigned  q, cand;
    rhs = num;
    rhs = (rhs * rhs) << 30;
    d   = vt;
    d   = d * vp;
    q   = 0;
    for (int b = 15; b >= 0; b--) begin
      cand = q | (1 << b);
      if (cand <= 32768) begin
        lhs = cand * cand;
        lhs = lhs * d;
        if (lhs <= rhs) q = cand;
      end
    end
    return q;
  endfunction

  function automatic match_t best_window();
    match_t          r;
    longint unsigned n, vt, vp, sp, sp2, stp, p, num;
    int unsigned     q, best, bx, by;
    r    = '0;
    best = 0;
    bx   = 0;
    by   = 0;
    n    = tpl_w * tpl_h;
    if (n * tpl_sq <= tpl_sum * tpl_sum) return r;
    vt = n * tpl_sq - tpl_sum * tpl_sum;
    for (int y = 0; y + tpl_h <= img_h; y++) begin
      for (int x = 0; x + tpl_w <= img_w; x++) begin
        sp = 0; sp2 = 0; stp = 0;
        for (int rr = 0; rr < tpl_h; rr++) begin
          for (int cc = 0; cc < tpl_w; cc++) begin
            p    = img_mem[(y + rr) * img_w + x + cc];
            sp  += p;
            sp2 += p * p;
            stp += p * tpl_mem[rr * tpl_w + cc];
          end
        end
        if (n * sp2 > sp * sp && n * stp > tpl_sum * sp) begin
          vp  = n * sp2 - sp * sp;
          num = n * stp - tpl_sum * sp;
          q   = zncc_q(num, vt, vp);
          if (q > best) begin
            best = q;
            bx   = x;
            by   = y;
          end
        end
      end
    end
    r.x     = 8'(bx);
    r.y     = 8'(by);
    r.score = (best > 32767) ? SCORE_SAT : 15'(best);
    r.found = (best > 0);
    return r;
  endfunction

  function automatic bit match_pixel(bit kind, bit [7:0] p, output match_t r);
    r = '0;
    if (kind == TPL) begin
      if (tpl_cnt < tpl_w * tpl_h) begin
        tpl_mem[tpl_cnt] = p;
        tpl_sum += p;
        tpl_sq  += p * p;
        tpl_cnt++;
      end
    end else if (img_cnt < img_w * img_h) begin
      img_mem[img_cnt] = p;
      img_cnt++;
    end
    if (tpl_cnt < tpl_w * tpl_h || img_cnt < img_w * img_h) return 0;
    if (tpl_w > img_w || tpl_h > img_h) r.status = 1'b1;
    else r = best_window();
    clear_frame();
    return 1;
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             matches_seen);
    errors++;
  endtask

  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        want = pending_matches.pop_front();
        if (out_match_x !== want.x) report("match_x", out_match_x, want.x);
        if (out_match_y !== want.y) report("match_y", out_match_y, want.y);
        if (out_best_score !== want.score) report("best_score", out_best_score, want.score);
        if (out_found !== want.found) report("found", out_found, want.found);
        if (out_status !== want.status) report("status", out_status, want.status);
      end
      matches_seen++;
    end
  end

  initial begin
    int r;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (r < 88) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 94) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (200) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(bit kind, bit [7:0] p, int gap, bit typed, match_t tres);
    match_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_pixel    <= p;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (match_pixel(kind, p, r))
      pending_matches.insert(pending_matches.size(), typed ? tres : r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    wait (pending_matches.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [8:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    match_config(idx, d);
    @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] idx, int unsigned v);
    cfg_write(idx, (v == 1 && $urandom_range(0, 3) == 0) ? 9'd0 : 9'(v));
  endtask

  task automatic play_frame(bit reconfig, int unsigned w, int unsigned h,
                            int unsigned tw, int unsigned th);
    bit [7:0]    tp[$], ip[$], seq_pix[$];
    bit          seq_kind[$];
    int unsigned tn, nn, ti, ii, tmode, imode, ox, oy, order;
    bit [7:0]    base, alt;
    if (reconfig) begin
      settle();
      write_size(CFG_IMAGE_W, w);
      write_size(CFG_IMAGE_H, h);
      write_size(CFG_TEMPLATE_W, tw);
      write_size(CFG_TEMPLATE_H, th);
      settings_used++;
    end
    tn    = tpl_w * tpl_h;
    nn    = img_w * img_h;
    tmode = $urandom_range(0, 9);
    imode = $urandom_range(0, 9);
    base  = 8'($urandom);
    alt   = 8'($urandom);
    for (int k = 0; k < tn; k++) begin
      if (tmode == 0) tp.insert(tp.size(), base);
      else if (tmode < 3) tp.insert(tp.size(), $urandom_range(0, 1) ? base : alt);
      else tp.insert(tp.size(), 8'($urandom));
    end
    for (int k = 0; k < nn; k++) ip.insert(ip.size(), imode == 0 ? base : 8'($urandom));
    if (imode > 3 && tpl_w <= img_w && tpl_h <= img_h) begin
      ox = $urandom_range(0, img_w - tpl_w);
      oy = $urandom_range(0, img_h - tpl_h);
      for (int k = 0; k < tn; k++)
        ip[(oy + k / tpl_w) * img_w + ox + k % tpl_w] =
          (imode > 6) ? tp[k] : 8'(tp[k] + $urandom_range(0, 7));
    end
    order = $urandom_range(0, 2);
    ti = 0;
    ii = 0;
    while (ti < tn || ii < nn) begin
      if (ii >= nn || (ti < tn && (order == 0 || (order == 2 && $urandom_range(0, 1))))) begin
        seq_kind.insert(seq_kind.size(), TPL);
        seq_pix.insert(seq_pix.size(), tp[ti++]);
      end else begin
        seq_kind.insert(seq_kind.size(), IMG);
        seq_pix.insert(seq_pix.size(), ip[ii++]);
      end
    end
    // Words for a store that is already full are dropped by the block.
    if ($urandom_range(0, 4) == 0) begin
      for (int k = $urandom_range(1, 2); k > 0; k--) begin
        seq_kind.insert(seq_kind.size() - 1, !seq_kind[seq_kind.size() - 1]);
        seq_pix.insert(seq_pix.size() - 1, 8'($urandom));
      end
    end
    if (reconfig && $urandom_range(0, 14) == 0) void'(seq_kind.pop_back());
    foreach (seq_kind[k]) send_pixel(seq_kind[k], seq_pix[k], pick_gap(), 1'b0, '0);
  endtask

  localparam match_t NO_MATCH = '0;
  localparam match_t TOO_BIG  = '{x: 8'd0, y: 8'd0, score: 15'd0, found: 1'b0, status: 1'b1};
  localparam match_t PERFECT0 = '{x: 8'd1, y: 8'd0, score: SCORE_SAT, found: 1'b1, status: 1'b0};

  localparam plan_row_t DIRECTED [30] = '{
    '{1'b1, CFG_IMAGE_W,    9'd511, TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b1, CFG_IMAGE_H,    9'd256, TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b1, CFG_TEMPLATE_W, 9'd63,  TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b1, CFG_TEMPLATE_H, 9'd32,  TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b1, CFG_IMAGE_W,    9'd0,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b1, CFG_IMAGE_H,    9'd0,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b1, CFG_TEMPLATE_W, 9'd0,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b1, CFG_TEMPLATE_H, 9'd0,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd255, 1'b1, NO_MATCH},
    '{1'b1, CFG_TEMPLATE_W, 9'd2,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd10,  1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd20,  1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd7,   1'b1, TOO_BIG},
    '{1'b1, CFG_IMAGE_W,    9'd3,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd0,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd255, 1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd255, 1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd0,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd9,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd255, 1'b1, PERFECT0},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd3,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd3,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd1,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd2,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd3,   1'b1, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd1,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   TPL, 8'd2,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd5,   1'b0, NO_MATCH},
    '{1'b0, CFG_IMAGE_W,    9'd0,   IMG, 8'd5,   1'b0, NO_MATCH}
  };

  initial begin
    #400ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned w, h, frames;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = 1'b0;
    in_pixel    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    hold_req    = 0;
    img_w = 256; img_h = 256; tpl_w = 32; tpl_h = 32;
    clear_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[k]) begin
      if (DIRECTED[k].is_cfg) begin
        if (k == 0 || !DIRECTED[k - 1].is_cfg) settle();
        cfg_write(DIRECTED[k].idx, DIRECTED[k].data);
      end else begin
        send_pixel(DIRECTED[k].kind, DIRECTED[k].pix, 0, DIRECTED[k].typed,
                   DIRECTED[k].res);
      end
    end
    // The last directed frame is still open; one more image word completes it.
    send_pixel(IMG, 8'd5, 0, 1'b0, '0);

    // Widest and tallest settings, kept cheap by making the template too big.
    play_frame(1'b1, 256, 1, 1, 2);
    play_frame(1'b1, 1, 256, 32, 1);

    frames = 0;
    while (words_sent < 900) begin
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0)
        play_frame(1'b1, w, h, w + 1, $urandom_range(1, 3));
      else
        play_frame(1'b1, w, h, $urandom_range(1, w < 3 ? w : 3),
                   $urandom_range(1, h < 3 ? h : 3));
      frames++;
      if (frames == 3) hold_req = 1;
      // Back-to-back frames on the same setting load while a result waits.
      while ($urandom_range(0, 2) == 0 || frames == 3) begin
        play_frame(1'b0, 0, 0, 0, 0);
        frames++;
      end
    end

    in_valid <= 1'b0;
    wait (pending_matches.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d pixel words and %0d results over %0d size settings,",
             words_sent, matches_seen, settings_used);
    $display("including too-big templates, flat windows and stalled result words.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
